// ----- hw/rtl/i2a_pkg.sv -----
// shared types, opcodes and character helpers for the integer to ascii formatter
package i2a_pkg;

	localparam int VALUE_W   = 64;
	localparam int DIGITS    = 16;
	localparam int BCD_W     = 40;
	localparam int DAB_STEPS = 16;

	// opcodes
	localparam logic [2:0] OP_SDEC = 3'd0;
	localparam logic [2:0] OP_UDEC = 3'd1;
	localparam logic [2:0] OP_HEXL = 3'd2;
	localparam logic [2:0] OP_HEXU = 3'd3;
	localparam logic [2:0] OP_PTR  = 3'd4;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_UA    = 8'h41;

	localparam logic [7:0] NIL_TEXT [5] = '{8'h28, 8'h6e, 8'h69, 8'h6c, 8'h29};
	localparam logic [4:0] NIL_LEN = 5'd5;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [63:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
		logic [4:0] char_count;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic scan;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic last_char;
		logic out_free;
	} dp_status_t;

	// ascii for one digit in decimal, lower hex or upper hex
	function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'b0, d};
		end else if (upper) begin
			c = CH_UA + {4'b0, d} - 8'd10;
		end else begin
			c = CH_LA + {4'b0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/i2a_ctrl.sv -----
// controller state machine: load, decimal conversion, digit scan, character emission
module i2a_ctrl
	import i2a_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] in_opcode,
	output logic       in_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	localparam int CNT_W = $clog2(DAB_STEPS);

	state_t           state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             op_ok;
	logic             op_dec;

	assign accept = in_valid && in_ready;
	assign op_ok  = (in_opcode == OP_SDEC) || (in_opcode == OP_UDEC) ||
		(in_opcode == OP_HEXL) || (in_opcode == OP_HEXU) || (in_opcode == OP_PTR);
	assign op_dec = (in_opcode == OP_SDEC) || (in_opcode == OP_UDEC);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op_ok) begin
					state_nx = op_dec ? ST_CONV : ST_SCAN;
				end
			end
			ST_CONV: begin
				if (cnt_q == CNT_W'(DAB_STEPS - 1)) begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free && status.last_char) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = accept;
			end
			ST_CONV: begin
				cmd.step = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state and conversion step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CONV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

// ----- hw/rtl/i2a_dp.sv -----
// datapath: operand load, double dabble, digit count and output register
module i2a_dp
	import i2a_pkg::*;
#(
	parameter int POINTER_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_data,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	localparam logic [VALUE_W-1:0] PTR_MASK = {VALUE_W{1'b1}} >> (VALUE_W - POINTER_BITS);

	logic [2:0]          mode_q;
	logic                neg_q;
	logic [31:0]         bin_q;
	logic [4*DIGITS-1:0] digits_q;
	logic [4:0]          len_q;
	logic [1:0]          prefix_q;
	logic                nil_q;
	logic [4:0]          char_idx_q;
	logic [3:0]          dig_pos_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [31:0]       low;
	logic              in_neg;
	logic [71:0]       dab_nx;
	logic [3:0]        hi_dig;
	logic [1:0]        prefix_nx;
	logic              nil_nx;
	logic [3:0]        cur_dig;
	logic [7:0]        cur_char;
	logic              in_prefix;
	logic              is_last;

	// two shift-and-add-3 steps on {bcd, binary}
	function automatic logic [71:0] dabble2(logic [71:0] s);
		logic [71:0] t;
		t = s;
		for (int j = 0; j < 2; j++) begin
			for (int d = 0; d < 10; d++) begin
				if (t[32+4*d +: 4] >= 4'd5) begin
					t[32+4*d +: 4] = t[32+4*d +: 4] + 4'd3;
				end
			end
			t = t << 1;
		end
		return t;
	endfunction

	assign low    = in_data.value[31:0];
	assign in_neg = (in_data.opcode == OP_SDEC) && low[31];
	assign dab_nx = dabble2({digits_q[BCD_W-1:0], bin_q});

	// highest nonzero digit, zero when all are zero
	always_comb begin
		hi_dig = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (digits_q[4*i +: 4] != 4'd0) begin
				hi_dig = 4'(i);
			end
		end
	end

	assign nil_nx    = (mode_q == OP_PTR) && (digits_q == '0);
	assign prefix_nx = neg_q ? 2'd1 : ((mode_q == OP_PTR) ? 2'd2 : 2'd0);

	// character selection for the current position
	assign in_prefix = char_idx_q < {3'b0, prefix_q};
	assign cur_dig   = digits_q[{dig_pos_q, 2'b00} +: 4];
	always_comb begin
		if (nil_q) begin
			cur_char = NIL_TEXT[char_idx_q[2:0]];
		end else if (in_prefix) begin
			if (neg_q) begin
				cur_char = CH_MINUS;
			end else begin
				cur_char = char_idx_q[0] ? CH_X : CH_ZERO;
			end
		end else begin
			cur_char = digit_char(cur_dig, mode_q == OP_HEXU);
		end
	end

	assign is_last          = char_idx_q == (len_q - 5'd1);
	assign status.last_char = is_last;
	assign status.out_free  = !out_valid_q || out_ready;

	// operand and conversion registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_data.opcode;
			neg_q  <= in_neg;
			bin_q  <= in_neg ? (~low + 32'd1) : low;
			if (in_data.opcode == OP_PTR) begin
				digits_q <= in_data.value & PTR_MASK;
			end else if ((in_data.opcode == OP_HEXL) || (in_data.opcode == OP_HEXU)) begin
				digits_q <= {32'b0, low};
			end else begin
				digits_q <= '0;
			end
		end else if (cmd.step) begin
			digits_q[BCD_W-1:0] <= dab_nx[71:32];
			bin_q               <= dab_nx[31:0];
		end
		if (cmd.scan) begin
			nil_q      <= nil_nx;
			prefix_q   <= prefix_nx;
			len_q      <= nil_nx ? NIL_LEN : ({3'b0, prefix_nx} + {1'b0, hi_dig} + 5'd1);
			char_idx_q <= '0;
			dig_pos_q  <= hi_dig;
		end else if (cmd.emit) begin
			char_idx_q <= char_idx_q + 5'd1;
			if (!nil_q && !in_prefix) begin
				dig_pos_q <= dig_pos_q - 4'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.char_code  <= cur_char;
			out_q.last       <= is_last;
			out_q.char_count <= is_last ? len_q : 5'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hw/rtl/integer_to_ascii_formatter_core.sv -----
// top level of the integer to ascii formatter
//
//  channel | direction | payload     | transfer when
//  in      | input     | in_item_t   | in_valid && in_ready
//  out     | output    | out_item_t  | out_valid && out_ready
//
// decimal modes: the controller takes the item, runs the double dabble (2 bits per
// cycle), scans the digits, then emits the characters one by one.
// hex and pointer modes skip the dabble and go from the item straight to the scan.
// one item is in flight at a time; in_ready is high only while idle.
// a stall on out holds the character in the output register and pauses emission.
// reset clears the controller and the output valid; no clearing pass.
module integer_to_ascii_formatter_core
	import i2a_pkg::*;
#(
	parameter int POINTER_BITS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	i2a_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (in_data.opcode),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.status    (status)
	);

	i2a_dp #(
		.POINTER_BITS (POINTER_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- hw/rtl/i2a_checker.sv -----
// port-level checker for the integer to ascii formatter, bound to the top level
module i2a_checker
	import i2a_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// count only on the final character
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.char_count == 5'd0)
		else $error("char_count nonzero before last");

	// final count in range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last |-> out_data.char_count >= 5'd1 &&
			out_data.char_count <= 5'd18)
		else $error("char_count out of range");

	// a valid item makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.opcode <= OP_PTR |=> !in_ready)
		else $error("ready after taking a valid item");

endmodule

bind integer_to_ascii_formatter_core i2a_checker u_i2a_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ----- test/i2a_text_checker.sv -----
// checker for the integer to ascii formatter: predicts each text and compares every character
`timescale 1ns / 1ps

module i2a_text_checker
	import i2a_pkg::*;
#(
	parameter int POINTER_BITS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        mismatch_count,
	output int        chars_pending
);

	out_item_t expected_chars[$];
	int        errors = 0;
	int        pending_n = 0;

	assign mismatch_count = errors;
	assign chars_pending  = pending_n;

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("%0t ns mismatch: %s got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	// ascii for one digit of a decimal or hex number
	function automatic logic [7:0] digit_ascii(logic [3:0] d, logic upper);
		if (d < 4'd10) begin
			return CH_ZERO + 8'(d);
		end
		return (upper ? CH_UA : CH_LA) + 8'(d) - 8'd10;
	endfunction

	// builds the text of one number and queues one expected char per character
	function automatic void predict_text(in_item_t item);
		logic [7:0]  text[$];
		logic [7:0]  rev[$];
		logic [31:0] low;
		logic [63:0] mag;
		logic [63:0] base;
		logic [63:0] ptr;
		logic        upper;
		logic        nil;
		out_item_t   want;
		int          len;

		low   = item.value[31:0];
		mag   = {32'd0, low};
		base  = 64'd10;
		upper = 1'b0;
		nil   = 1'b0;
		case (item.opcode)
			OP_SDEC: begin
				if (low[31]) begin
					text.push_back(CH_MINUS);
					mag = {32'd0, -low};
				end
			end
			OP_UDEC: begin
				base = 64'd10;
			end
			OP_HEXL: begin
				base = 64'd16;
			end
			OP_HEXU: begin
				base  = 64'd16;
				upper = 1'b1;
			end
			OP_PTR: begin
				ptr = item.value & ({64{1'b1}} >> (64 - POINTER_BITS));
				if (ptr == 64'd0) begin
					nil = 1'b1;
				end else begin
					text.push_back(CH_ZERO);
					text.push_back(CH_X);
					mag  = ptr;
					base = 64'd16;
				end
			end
			default: begin
				// unused opcodes produce no text
				return;
			end
		endcase

		if (nil) begin
			foreach (NIL_TEXT[k]) begin
				text.push_back(NIL_TEXT[k]);
			end
		end else begin
			// digits come out least significant first
			do begin
				rev.push_back(digit_ascii(4'(mag % base), upper));
				mag = mag / base;
			end while (mag != 64'd0);
			while (rev.size() > 0) begin
				text.push_back(rev.pop_back());
			end
		end

		len = text.size();
		for (int k = 0; k < len; k++) begin
			want.char_code  = text[k];
			want.last       = (k == len - 1);
			want.char_count = (k == len - 1) ? 5'(len) : 5'd0;
			expected_chars.push_back(want);
		end
	endfunction

	// compare each output transfer, then predict from each input transfer
	always @(posedge clk) begin
		out_item_t head;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch("char with no text expected", out_data.char_code, 0);
				end else begin
					head = expected_chars.pop_front();
					if (out_data.char_code !== head.char_code) begin
						report_mismatch("char_code", out_data.char_code, head.char_code);
					end
					if (out_data.last !== head.last) begin
						report_mismatch("last", out_data.last, head.last);
					end
					if (out_data.char_count !== head.char_count) begin
						report_mismatch("char_count", out_data.char_count, head.char_count);
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_text(in_data);
			end
			pending_n = expected_chars.size();
		end
	end

endmodule

// ----- test/integer_to_ascii_formatter_core_tb.sv -----
// testbench top for the integer to ascii formatter: stimulus, flow control and verdict
`timescale 1ns / 1ps

module integer_to_ascii_formatter_core_tb;
	import i2a_pkg::*;

	localparam int PTR_BITS      = 64;
	localparam int RANDOM_ITEMS  = 120;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 40;

	// opcodes the block does not use
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	int        mismatch_count;
	int        chars_pending;
	bit        sender_bursting = 1'b0;

	always #5 clk = ~clk;

	integer_to_ascii_formatter_core #(
		.POINTER_BITS(PTR_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	i2a_text_checker #(
		.POINTER_BITS(PTR_BITS)
	) text_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.mismatch_count(mismatch_count),
		.chars_pending (chars_pending)
	);

	// offer one number, after a random gap unless bursting
	task automatic send_item(logic [2:0] op, logic [63:0] val);
		int gap;
		gap = sender_bursting ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= '{opcode: op, value: val};
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// stop offering until every expected char has arrived or the limit runs out
	task automatic drain_text(int limit);
		int waited;
		in_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (chars_pending != 0 && waited < limit) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// values weighted toward digit-count and sign boundaries
	function automatic logic [63:0] random_value();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: return r;
			1: return {r[63:32] & {32{r[0]}}, 32'($urandom_range(0, 99))};
			2: return {r[63:32], 32'h8000_0000 + 32'($urandom_range(0, 3))};
			3: return {r[63:32], 32'hFFFF_FFFF - 32'($urandom_range(0, 3))};
			4: return {r[63:32] & {32{r[1]}}, 32'd0};
			default: return r >> $urandom_range(0, 63);
		endcase
	endfunction

	// receiver: random stalls, fast stretches, and two long hold-offs
	initial begin : sink
		int stall;
		int taken;
		bit fast;
		taken = 0;
		fast  = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == 50 || taken == 400) begin
				stall = LONG_HOLD;
			end else begin
				stall = fast ? 0 : $urandom_range(0, 10);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			taken++;
			if (taken % 30 == 0) begin
				fast = ($urandom_range(0, 3) == 0);
			end
		end
	end

	// reset, directed numbers, random numbers, verdict
	initial begin : stimulus
		int          sent;
		logic [2:0]  op;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// zeros, extremes, digit sets, ignored upper bits and reserved opcodes
		send_item(OP_SDEC, 64'd0);
		send_item(OP_SDEC, 64'h0000_0000_7FFF_FFFF);
		send_item(OP_SDEC, 64'h0000_0000_8000_0000);
		send_item(OP_SDEC, 64'h0000_0000_FFFF_FFFF);
		send_item(OP_SDEC, 64'hFFFF_FFFF_0000_0001);
		send_item(OP_SDEC, 64'h0000_0000_8000_0001);
		send_item(OP_UDEC, 64'd0);
		send_item(OP_UDEC, 64'h0000_0000_FFFF_FFFF);
		send_item(OP_UDEC, 64'hABCD_0000_3B9A_CA00);
		send_item(OP_UDEC, 64'd9);
		send_item(OP_HEXL, 64'd0);
		send_item(OP_HEXL, 64'h0000_0000_89AB_CDEF);
		send_item(OP_HEXL, 64'hFFFF_FFFF_0123_4567);
		send_item(OP_HEXU, 64'd0);
		send_item(OP_HEXU, 64'h0000_0000_89AB_CDEF);
		send_item(OP_HEXU, 64'h0000_0000_FFFF_FFFF);
		send_item(OP_PTR, 64'd0);
		send_item(OP_PTR, {64{1'b1}});
		send_item(OP_PTR, 64'd1);
		send_item(OP_PTR, 64'h8000_0000_0000_0000);
		send_item(OP_PTR, 64'h0123_4567_89AB_CDEF);
		send_item(OP_RSVD5, 64'h0000_0000_1234_5678);
		send_item(OP_RSVD6, {64{1'b1}});
		send_item(OP_RSVD7, 64'd0);
		send_item(OP_HEXU, 64'h0000_0000_0000_000A);
		drain_text(DRAIN_LIMIT);

		// random numbers, with one full drain halfway
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 20 == 0) begin
				sender_bursting = ($urandom_range(0, 2) == 0);
			end
			if ($urandom_range(0, 9) == 0) begin
				op = 3'($urandom_range(5, 7));
			end else begin
				op = 3'($urandom_range(0, 4));
			end
			send_item(op, random_value());
			if (op <= OP_PTR) begin
				sent++;
				if (sent == RANDOM_ITEMS / 2) begin
					drain_text(DRAIN_LIMIT);
				end
			end
		end

		drain_text(DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && chars_pending == 0) begin
			$display("integer_to_ascii_formatter_core_tb passed");
		end else begin
			$display("integer_to_ascii_formatter_core_tb failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("integer_to_ascii_formatter_core_tb failed");
		$finish;
	end

endmodule

// ----- integer_to_ascii_formatter_core.f -----
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_ctrl.sv
hw/rtl/i2a_dp.sv
hw/rtl/integer_to_ascii_formatter_core.sv
hw/rtl/i2a_checker.sv
test/i2a_text_checker.sv
test/integer_to_ascii_formatter_core_tb.sv
